FILE: rtl/core/lzwd_pkg.sv
// lzwd_pkg: shared constants and request and response types of the .Z decoder
`timescale 1ns / 1ps
package lzwd_pkg;

  localparam logic [7:0]  MagicA     = 8'h1F;
  localparam logic [7:0]  MagicB     = 8'h9D;
  localparam int unsigned BlockBit   = 7;
  localparam logic [8:0]  ClearCode  = 9'd256;
  localparam logic [16:0] FirstFree  = 17'd257;
  localparam logic [4:0]  StartWidth = 5'd9;
  localparam logic [4:0]  TopWidth   = 5'd16;
  localparam logic [16:0] NoCode     = 17'h1FFFF;

  // decoder phase
  localparam logic [2:0] PhMagicA   = 3'd0;
  localparam logic [2:0] PhMagicB   = 3'd1;
  localparam logic [2:0] PhFlags    = 3'd2;
  localparam logic [2:0] PhFirst    = 3'd3;
  localparam logic [2:0] PhRun      = 3'd4;
  localparam logic [2:0] PhEnd      = 3'd5;
  localparam logic [2:0] PhBadMagic = 3'd6;
  localparam logic [2:0] PhBadWidth = 3'd7;

  // result status
  localparam logic [2:0] StAccepted  = 3'd0;
  localparam logic [2:0] StDelivered = 3'd1;
  localparam logic [2:0] StNothing   = 3'd2;
  localparam logic [2:0] StBusy      = 3'd3;
  localparam logic [2:0] StBadMagic  = 3'd4;
  localparam logic [2:0] StBadWidth  = 3'd5;
  localparam logic [2:0] StEnded     = 3'd6;
  localparam logic [2:0] StEmpty     = 3'd7;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [15:0] wprefix;
    logic [7:0]  wsuffix;
    logic [15:0] raddr;
  } dict_req_t;

  typedef struct packed {
    logic [15:0] prefix;
    logic [7:0]  suffix;
  } dict_rsp_t;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic [15:0] raddr;
  } stk_req_t;

endpackage

FILE: rtl/core/lzwd_in_if.sv
// lzwd_in_if: input channel carrying feed and pull requests
`timescale 1ns / 1ps
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, op, in_byte, in_last, input ready);
  modport sink (input valid, op, in_byte, in_last, output ready);
endinterface

FILE: rtl/core/lzwd_out_if.sv
// lzwd_out_if: result channel of the decoder
`timescale 1ns / 1ps
interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic [2:0] status;
  modport source (output valid, out_byte, out_valid, out_last, status, input ready);
  modport sink (input valid, out_byte, out_valid, out_last, status, output ready);
endinterface

FILE: rtl/core/lzw_compress_z_decoder_top.sv
// lzw_compress_z_decoder_top: .Z stream decoder, control sequencer and memories
//
//  channel  dir  payload                             handshake
//  src_i    in   op, in_byte, in_last                valid/ready
//  dst_o    out  out_byte, out_valid, out_last, st   valid/ready
//
// header bytes and code bytes that finish no code answer from idle, a pull via SPull.
// a finished first code or clear passes SCode and SFin, any other code SCode, then
// SWalk and SWait per dictionary entry walked, SLastRd when the stack fills, and SFin.
// the walk is bounded by one dictionary memory read a step. no clearing pass after reset.
// a new word is taken only when the sequencer is idle and the result register is empty.
`timescale 1ns / 1ps
module lzw_compress_z_decoder_top #(
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzwd_in_if.sink    src_i,
  lzwd_out_if.source dst_o
);
  import lzwd_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SPull   = 3'd1;
  localparam logic [2:0] SCode   = 3'd2;
  localparam logic [2:0] SWalk   = 3'd3;
  localparam logic [2:0] SWait   = 3'd4;
  localparam logic [2:0] SLastRd = 3'd5;
  localparam logic [2:0] SFin    = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [2:0]  phase_q, phase_d;
  logic [16:0] depth_q, depth_d;
  logic [4:0]  wl_q, wl_d;
  logic        blk_q, blk_d;
  logic [4:0]  cw_q, cw_d;
  logic [16:0] nf_q, nf_d;
  logic [23:0] acc_q, acc_d;
  logic [4:0]  bits_q, bits_d;
  logic [4:0]  gl_q, gl_d;
  logic [4:0]  skip_q, skip_d;
  logic [16:0] prev_q, prev_d;
  logic [7:0]  lc_q, lc_d;
  logic        clr_q, clr_d;
  logic [15:0] code_q, code_d;
  logic [16:0] incode_q, incode_d;
  logic [15:0] c_q, c_d;
  logic        last_q, last_d;

  logic        ovld_q, ovld_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        oval_q, oval_d;
  logic        olast_q, olast_d;
  logic [2:0]  ost_q, ost_d;

  dict_req_t dreq;
  dict_rsp_t drsp;
  stk_req_t  sreq;
  logic [7:0] srd;

  lzwd_dict #(.AW(MAX_CODE_BITS)) u_dict (.clk_i(clk_i), .req_i(dreq), .rsp_o(drsp));
  lzwd_stack u_stack (.clk_i(clk_i), .req_i(sreq), .rdata_o(srd));

  logic        acc_in;
  logic [23:0] acc_new, cmask;
  logic [4:0]  bits_new;
  logic [16:0] maxcode;
  logic [17:0] tab_lim;
  logic        push;
  logic [7:0]  push_b;
  logic        close;
  logic [7:0]  close_lc;
  logic        drop;

  assign acc_in  = src_i.valid && src_i.ready;
  assign acc_new = acc_q | (24'(src_i.in_byte) << bits_q);
  assign bits_new = bits_q + 5'd8;
  assign cmask   = (24'd1 << cw_q) - 24'd1;
  assign maxcode = (cw_q != StartWidth && cw_q == wl_q) ? (17'd1 << wl_q)
                                                        : ((17'd1 << cw_q) - 17'd1);
  assign tab_lim = 18'd1 << wl_q;

  assign src_i.ready     = (state_q == SIdle) && !ovld_q;
  assign dst_o.valid     = ovld_q;
  assign dst_o.out_byte  = obyte_q;
  assign dst_o.out_valid = oval_q;
  assign dst_o.out_last  = olast_q;
  assign dst_o.status    = ost_q;

  always_comb begin
    state_d = state_q; phase_d = phase_q; depth_d = depth_q; wl_d = wl_q;
    blk_d = blk_q; cw_d = cw_q; nf_d = nf_q; acc_d = acc_q; bits_d = bits_q;
    gl_d = gl_q; skip_d = skip_q; prev_d = prev_q; lc_d = lc_q; clr_d = clr_q;
    code_d = code_q; incode_d = incode_q; c_d = c_q; last_d = last_q;
    ovld_d = ovld_q && !dst_o.ready; obyte_d = obyte_q; oval_d = oval_q;
    olast_d = olast_q; ost_d = ost_q;
    dreq = '0; sreq = '0;
    dreq.raddr = c_q;
    sreq.raddr = 16'(depth_q - 17'd1);
    push = 1'b0; push_b = lc_q;
    close = 1'b0; close_lc = lc_q;
    drop = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (acc_in) begin
          ovld_d = 1'b1; oval_d = 1'b0; olast_d = 1'b0; obyte_d = 8'd0;
          ost_d = StAccepted;
          if (src_i.op) begin
            if (depth_q != 17'd0) begin
              depth_d = depth_q - 17'd1;
              ovld_d = 1'b0;
              state_d = SPull;
            end else begin
              ost_d = (phase_q >= PhEnd) ? StEmpty : StNothing;
            end
          end else if (phase_q == PhBadMagic) begin
            ost_d = StBadMagic;
          end else if (phase_q == PhBadWidth) begin
            ost_d = StBadWidth;
          end else if (phase_q == PhEnd) begin
            ost_d = StEnded;
          end else if (depth_q != 17'd0) begin
            ost_d = StBusy;
          end else begin
            unique case (phase_q)
              PhMagicA: begin
                if (src_i.in_byte != MagicA) begin
                  phase_d = PhBadMagic; ost_d = StBadMagic;
                end else phase_d = PhMagicB;
              end
              PhMagicB: begin
                if (src_i.in_byte != MagicB) begin
                  phase_d = PhBadMagic; ost_d = StBadMagic;
                end else phase_d = PhFlags;
              end
              PhFlags: begin
                if (src_i.in_byte[4:0] > 5'(MAX_CODE_BITS)) begin
                  phase_d = PhBadWidth; ost_d = StBadWidth;
                end else begin
                  wl_d = src_i.in_byte[4:0];
                  blk_d = src_i.in_byte[BlockBit];
                  nf_d = src_i.in_byte[BlockBit] ? FirstFree : 17'(ClearCode);
                  phase_d = PhFirst;
                end
              end
              default: begin
                if (skip_q != 5'd0) begin
                  skip_d = skip_q - 5'd1;
                end else begin
                  gl_d = ((gl_q == 5'd0) ? cw_q : gl_q) - 5'd1;
                  if (bits_new >= cw_q) begin
                    code_d = 16'(acc_new & cmask);
                    acc_d = acc_new >> cw_q;
                    bits_d = bits_new - cw_q;
                    last_d = src_i.in_last;
                    ovld_d = 1'b0;
                    state_d = SCode;
                  end else begin
                    acc_d = acc_new;
                    bits_d = bits_new;
                  end
                end
              end
            endcase
            if (state_d == SIdle && ost_d == StAccepted && src_i.in_last) phase_d = PhEnd;
          end
        end
      end
      SPull: begin
        ovld_d = 1'b1; oval_d = 1'b1; obyte_d = srd; ost_d = StDelivered;
        olast_d = (depth_q == 17'd0) && (phase_q == PhEnd);
        state_d = SIdle;
      end
      SCode: begin
        if (phase_q == PhFirst) begin
          lc_d = code_q[7:0]; push = 1'b1; push_b = code_q[7:0];
          prev_d = 17'(code_q); phase_d = PhRun;
          state_d = SFin;
        end else if (code_q == 16'(ClearCode) && blk_q) begin
          clr_d = 1'b1; nf_d = 17'(ClearCode);
          state_d = SFin;
        end else begin
          incode_d = 17'(code_q);
          if (17'(code_q) >= nf_q) begin
            push = 1'b1; push_b = lc_q;
            c_d = prev_q[15:0];
          end else c_d = code_q;
          state_d = SWalk;
        end
      end
      SWalk: begin
        if (c_q >= 16'd256) begin
          state_d = (depth_q < 17'd65535) ? SWait : SLastRd;
        end else begin
          close = 1'b1; close_lc = c_q[7:0];
        end
      end
      SWait: begin
        push = 1'b1; push_b = drsp.suffix;
        c_d = drsp.prefix;
        state_d = SWalk;
      end
      SLastRd: begin
        close = 1'b1; close_lc = drsp.suffix;
      end
      SFin: begin
        if (nf_q > maxcode) begin
          if (cw_q < TopWidth) cw_d = cw_q + 5'd1;
          drop = 1'b1;
        end
        if (clr_q) begin
          cw_d = StartWidth; clr_d = 1'b0; drop = 1'b1;
        end
        if (drop) begin
          skip_d = gl_q; gl_d = 5'd0; acc_d = '0; bits_d = 5'd0;
        end
        if (last_q) phase_d = PhEnd;
        ovld_d = 1'b1; oval_d = 1'b0; olast_d = 1'b0; obyte_d = 8'd0;
        ost_d = StAccepted;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase

    if (close) begin
      lc_d = close_lc; push = 1'b1; push_b = close_lc;
      if (18'(nf_q) < tab_lim && nf_q < 17'd65536) begin
        dreq.we = 1'b1; dreq.waddr = nf_q[15:0];
        dreq.wprefix = prev_q[15:0]; dreq.wsuffix = close_lc;
        nf_d = nf_q + 17'd1;
      end
      prev_d = incode_q;
      state_d = SFin;
    end

    // push onto the stack, dropped once it is full
    if (push && depth_q < 17'd65536) begin
      sreq.we = 1'b1; sreq.waddr = depth_q[15:0]; sreq.wdata = push_b;
      depth_d = depth_q + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; phase_q <= PhMagicA; depth_q <= '0; wl_q <= '0; blk_q <= 1'b0;
      cw_q <= StartWidth; nf_q <= FirstFree; acc_q <= '0; bits_q <= '0; gl_q <= '0;
      skip_q <= '0; prev_q <= NoCode; lc_q <= '0; clr_q <= 1'b0; last_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; depth_q <= depth_d; wl_q <= wl_d;
      blk_q <= blk_d; cw_q <= cw_d; nf_q <= nf_d; acc_q <= acc_d; bits_q <= bits_d;
      gl_q <= gl_d; skip_q <= skip_d; prev_q <= prev_d; lc_q <= lc_d; clr_q <= clr_d;
      last_q <= last_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d; incode_q <= incode_d; c_q <= c_d;
    obyte_q <= obyte_d; oval_q <= oval_d; olast_q <= olast_d; ost_q <= ost_d;
  end

  a_deliver_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_o.valid && dst_o.out_valid |-> dst_o.status == StDelivered)
    else $error("delivered word without delivered status");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 17'd65536)
    else $error("stack depth overflow");
  a_pull_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && src_i.op && depth_q != 17'd0 |=> state_q == SPull && !dst_o.valid)
    else $error("pull did not start a stack read");
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q >= StartWidth && cw_q <= TopWidth)
    else $error("code width out of range");

endmodule

FILE: rtl/core/lzwd_dict.sv
// lzwd_dict: prefix and suffix dictionary memories
`timescale 1ns / 1ps
module lzwd_dict #(
  parameter int unsigned AW = 16
) (
  input  logic               clk_i,
  input  lzwd_pkg::dict_req_t req_i,
  output lzwd_pkg::dict_rsp_t rsp_o
);
  import lzwd_pkg::*;

  logic [15:0] prefix_mem [2**AW];
  logic [7:0]  suffix_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      prefix_mem[req_i.waddr[AW-1:0]] <= req_i.wprefix;
      suffix_mem[req_i.waddr[AW-1:0]] <= req_i.wsuffix;
    end
    rsp_o.prefix <= prefix_mem[req_i.raddr[AW-1:0]];
    rsp_o.suffix <= suffix_mem[req_i.raddr[AW-1:0]];
  end

endmodule

FILE: rtl/core/lzwd_stack.sv
// lzwd_stack: expansion stack memory
`timescale 1ns / 1ps
module lzwd_stack (
  input  logic              clk_i,
  input  lzwd_pkg::stk_req_t req_i,
  output logic [7:0]        rdata_o
);
  import lzwd_pkg::*;

  logic [7:0] stk_mem [65536];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      stk_mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= stk_mem[req_i.raddr];
  end

endmodule
